[hdl/trrb_pkg.sv]
// ----------------------------------------------------------------------------
// trrb_pkg
// Shared types, constants and helpers for the tagged record ring buffer.
// ----------------------------------------------------------------------------
package trrb_pkg;

	// Ring geometry
	localparam int RING_BYTES = 256;
	localparam int AW         = $clog2(RING_BYTES);
	localparam int UW         = $clog2(RING_BYTES + 1);
	localparam int CMPW       = (UW > 9) ? UW : 9;

	// Header fields
	localparam logic [7:0] HDR_LOCKED       = 8'h80;
	localparam logic [7:0] HDR_VALID        = 8'h40;
	localparam logic [7:0] HDR_LOCKED_VALID = 8'hC0;
	localparam logic [7:0] HDR_TYPE         = 8'h3F;
	localparam logic [5:0] EMPTY_CODE       = 6'd0;

	// Command codes
	typedef enum logic [2:0] {
		ACT_QUERY    = 3'd0,
		ACT_OPEN_WR  = 3'd1,
		ACT_WR_BYTE  = 3'd2,
		ACT_CLOSE_WR = 3'd3,
		ACT_OPEN_RD  = 3'd4,
		ACT_RD_BYTE  = 3'd5,
		ACT_CLOSE_RD = 3'd6
	} action_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_TAIL,
		ST_RESP
	} state_t;

	// Captured command beat
	typedef struct packed {
		action_t      action;
		logic [5:0]   rtype;
		logic [8:0]   len;
		logic [7:0]   data;
	} cmd_t;

	// Ring pointers and open-record bookkeeping
	typedef struct packed {
		logic [AW-1:0] head;
		logic [AW-1:0] tail;
		logic [UW-1:0] used;
		logic [7:0]    jobs;
		logic [AW-1:0] wr_hdr;
		logic [8:0]    wr_rem;
		logic          wr_open;
		logic [AW-1:0] rd_hdr;
		logic [8:0]    rd_rem;
		logic          rd_open;
	} ptr_t;

	// Outcome of one command
	typedef struct packed {
		logic          ok;
		logic [7:0]    rdata;
		logic          we;
		logic [AW-1:0] waddr;
		logic [7:0]    wdata;
		ptr_t          nxt;
	} upd_t;

	// Advance a ring position with wrap
	function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
		return (p == AW'(RING_BYTES - 1)) ? '0 : p + AW'(1);
	endfunction

endpackage

[hdl/trrb_ram.sv]
// ----------------------------------------------------------------------------
// trrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hdl/trrb_exec.sv]
// ----------------------------------------------------------------------------
// trrb_exec
// Evaluates one command against the fetched ring byte and the pointers.
// ----------------------------------------------------------------------------
module trrb_exec (
	input  trrb_pkg::cmd_t cmd,
	input  logic [7:0]     mem_byte,
	input  trrb_pkg::ptr_t cur,
	output trrb_pkg::upd_t upd
);

	logic [trrb_pkg::CMPW-1:0] len_w;
	logic [trrb_pkg::CMPW-1:0] used_w;
	logic [trrb_pkg::CMPW-1:0] free_w;
	logic                      type_match;

	assign len_w      = trrb_pkg::CMPW'(cmd.len);
	assign used_w     = trrb_pkg::CMPW'(cur.used);
	assign free_w     = trrb_pkg::CMPW'(trrb_pkg::RING_BYTES) - used_w;
	assign type_match = (mem_byte[5:0] == cmd.rtype);

	// Command decode and bookkeeping
	always_comb begin
		upd.ok    = 1'b0;
		upd.rdata = 8'd0;
		upd.we    = 1'b0;
		upd.waddr = cur.head;
		upd.wdata = 8'd0;
		upd.nxt   = cur;
		unique case (cmd.action)
			trrb_pkg::ACT_QUERY: begin
				upd.ok = 1'b1;
			end
			trrb_pkg::ACT_OPEN_WR: begin
				if (!cur.wr_open && cmd.len != 9'd0 && len_w <= free_w &&
				    (mem_byte & (trrb_pkg::HDR_LOCKED | trrb_pkg::HDR_VALID)) == 8'd0) begin
					upd.ok          = 1'b1;
					upd.we          = 1'b1;
					upd.waddr       = cur.head;
					upd.wdata       = trrb_pkg::HDR_LOCKED | {2'b00, cmd.rtype};
					upd.nxt.wr_hdr  = cur.head;
					upd.nxt.head    = trrb_pkg::next_pos(cur.head);
					upd.nxt.wr_rem  = cmd.len - 9'd1;
					upd.nxt.used    = cur.used + trrb_pkg::UW'(cmd.len);
					upd.nxt.wr_open = 1'b1;
				end
			end
			trrb_pkg::ACT_WR_BYTE: begin
				if (cur.wr_open && cur.wr_rem != 9'd0) begin
					upd.ok         = 1'b1;
					upd.we         = 1'b1;
					upd.waddr      = cur.head;
					upd.wdata      = cmd.data;
					upd.nxt.head   = trrb_pkg::next_pos(cur.head);
					upd.nxt.wr_rem = cur.wr_rem - 9'd1;
				end
			end
			trrb_pkg::ACT_CLOSE_WR: begin
				if (cur.wr_open && cur.wr_rem == 9'd0 && type_match) begin
					upd.ok          = 1'b1;
					upd.we          = 1'b1;
					upd.waddr       = cur.wr_hdr;
					upd.wdata       = trrb_pkg::HDR_VALID | {2'b00, cmd.rtype};
					upd.nxt.jobs    = cur.jobs + 8'd1;
					upd.nxt.wr_open = 1'b0;
				end
			end
			trrb_pkg::ACT_OPEN_RD: begin
				if (!cur.rd_open && cmd.len != 9'd0 && type_match && len_w <= used_w &&
				    !mem_byte[7] && mem_byte[6]) begin
					upd.ok          = 1'b1;
					upd.we          = 1'b1;
					upd.waddr       = cur.tail;
					upd.wdata       = trrb_pkg::HDR_LOCKED_VALID | {2'b00, cmd.rtype};
					upd.nxt.rd_hdr  = cur.tail;
					upd.nxt.tail    = trrb_pkg::next_pos(cur.tail);
					upd.nxt.rd_rem  = cmd.len - 9'd1;
					upd.nxt.used    = cur.used - trrb_pkg::UW'(cmd.len);
					upd.nxt.rd_open = 1'b1;
				end
			end
			trrb_pkg::ACT_RD_BYTE: begin
				// Byte is returned and its cell cleared
				if (cur.rd_open && cur.rd_rem != 9'd0) begin
					upd.ok         = 1'b1;
					upd.rdata      = mem_byte;
					upd.we         = 1'b1;
					upd.waddr      = cur.tail;
					upd.wdata      = 8'd0;
					upd.nxt.tail   = trrb_pkg::next_pos(cur.tail);
					upd.nxt.rd_rem = cur.rd_rem - 9'd1;
				end
			end
			trrb_pkg::ACT_CLOSE_RD: begin
				if (cur.rd_open && cur.rd_rem == 9'd0 && type_match) begin
					upd.ok          = 1'b1;
					upd.we          = 1'b1;
					upd.waddr       = cur.rd_hdr;
					upd.wdata       = {2'b00, trrb_pkg::EMPTY_CODE} & trrb_pkg::HDR_TYPE;
					upd.nxt.jobs    = cur.jobs - 8'd1;
					upd.nxt.rd_open = 1'b0;
				end
			end
			default: begin
				upd.ok = 1'b0;
			end
		endcase
	end

endmodule

[hdl/tagged_record_ring_buffer.sv]
// ----------------------------------------------------------------------------
// tagged_record_ring_buffer
// Byte ring holding variable-length records with a tagged header byte.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken on a rising edge with start high and
//   busy low; it carries action, record_type, record_length and write_data.
//   Result channel: done is high for exactly one cycle with ok, next_type,
//   read_data, pending_jobs and used_bytes; the receiver cannot stall it.
// Order: the command edge itself fetches the addressed ring byte; state
//   EXEC then executes and writes it back, state TAIL fetches the
//   header at the new tail, and done is high in state RESP, so the
//   result is taken at the rising edge that ends RESP.
// Overlap: busy is high in EXEC and TAIL; a new command may be taken in
//   the same cycle as the previous result, since busy is low there.
//   Each command needs the pointers and ring byte left by the one before,
//   and next_type needs the tail header after the write-back.
// Reset: arst_n clears all pointers and counters, then the block sweeps
//   the ring writing zero, one byte per cycle, to all RING_BYTES (256)
//   cells with busy high; no command is taken until the sweep is done.
// ----------------------------------------------------------------------------
module tagged_record_ring_buffer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] action,
	input  logic [5:0] record_type,
	input  logic [8:0] record_length,
	input  logic [7:0] write_data,
	output logic       done,
	output logic       ok,
	output logic [5:0] next_type,
	output logic [7:0] read_data,
	output logic [7:0] pending_jobs,
	output logic [8:0] used_bytes
);

	trrb_pkg::state_t            state_q, state_nxt;
	trrb_pkg::cmd_t              cmd_q;
	trrb_pkg::ptr_t              ptr_q;
	trrb_pkg::upd_t              upd;
	logic [trrb_pkg::AW-1:0]     clr_cnt_q;
	logic                        ok_q;
	logic [7:0]                  rdata_q;
	logic                        accept;
	logic                        clear_done;

	logic                        ram_we;
	logic [trrb_pkg::AW-1:0]     ram_waddr;
	logic [7:0]                  ram_wdata;
	logic [trrb_pkg::AW-1:0]     ram_raddr;
	logic [7:0]                  ram_rdata;
	logic [trrb_pkg::AW-1:0]     fetch_addr;

	assign accept     = start && !busy;
	assign clear_done = (clr_cnt_q == trrb_pkg::AW'(trrb_pkg::RING_BYTES - 1));

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			trrb_pkg::ST_CLEAR: if (clear_done) state_nxt = trrb_pkg::ST_IDLE;
			trrb_pkg::ST_IDLE:  if (accept) state_nxt = trrb_pkg::ST_EXEC;
			trrb_pkg::ST_EXEC:  state_nxt = trrb_pkg::ST_TAIL;
			trrb_pkg::ST_TAIL:  state_nxt = trrb_pkg::ST_RESP;
			trrb_pkg::ST_RESP: begin
				state_nxt = accept ? trrb_pkg::ST_EXEC : trrb_pkg::ST_IDLE;
			end
			default:            state_nxt = trrb_pkg::ST_CLEAR;
		endcase
	end

	// State outputs
	always_comb begin
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			trrb_pkg::ST_IDLE: busy = 1'b0;
			trrb_pkg::ST_RESP: begin
				busy = 1'b0;
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
				done = 1'b0;
			end
		endcase
	end

	// Ring byte the incoming command works on
	always_comb begin
		unique case (trrb_pkg::action_t'(action))
			trrb_pkg::ACT_OPEN_WR,
			trrb_pkg::ACT_WR_BYTE:  fetch_addr = ptr_q.head;
			trrb_pkg::ACT_CLOSE_WR: fetch_addr = ptr_q.wr_hdr;
			trrb_pkg::ACT_CLOSE_RD: fetch_addr = ptr_q.rd_hdr;
			default:                fetch_addr = ptr_q.tail;
		endcase
	end

	// RAM port steering: sweep at reset, write-back in execute
	always_comb begin
		ram_raddr = (state_q == trrb_pkg::ST_TAIL) ? ptr_q.tail : fetch_addr;
		if (state_q == trrb_pkg::ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = 8'd0;
		end else begin
			ram_we    = (state_q == trrb_pkg::ST_EXEC) && upd.we;
			ram_waddr = upd.waddr;
			ram_wdata = upd.wdata;
		end
	end

	trrb_ram #(
		.WIDTH(8),
		.DEPTH(trrb_pkg::RING_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	trrb_exec u_exec (
		.cmd      (cmd_q),
		.mem_byte (ram_rdata),
		.cur      (ptr_q),
		.upd      (upd)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= trrb_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
			ptr_q     <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == trrb_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + trrb_pkg::AW'(1);
			end
			if (state_q == trrb_pkg::ST_EXEC) begin
				ptr_q <= upd.nxt;
			end
		end
	end

	// Command capture and result hold
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.action <= trrb_pkg::action_t'(action);
			cmd_q.rtype  <= record_type;
			cmd_q.len    <= record_length;
			cmd_q.data   <= write_data;
		end
		if (state_q == trrb_pkg::ST_EXEC) begin
			ok_q    <= upd.ok;
			rdata_q <= upd.rdata;
		end
	end

	// Result beat; tail header arrives from the RAM in the response cycle
	assign ok           = ok_q;
	assign read_data    = rdata_q;
	assign next_type    = (!ram_rdata[7] && ram_rdata[6]) ? ram_rdata[5:0]
	                                                     : trrb_pkg::EMPTY_CODE;
	assign pending_jobs = ptr_q.jobs;
	assign used_bytes   = 9'(ptr_q.used);

endmodule

[tb/trrb_record_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trrb_record_checker
// Watches the command and result channels of the tagged record ring buffer,
// keeps its own copy of the ring and bookkeeping, and compares every result
// beat, field by field, with the status predicted for the oldest command.
// ----------------------------------------------------------------------------
module trrb_record_checker
	import trrb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  action,
	input  logic [5:0]  record_type,
	input  logic [8:0]  record_length,
	input  logic [7:0]  write_data,
	input  logic        done,
	input  logic        ok,
	input  logic [5:0]  next_type,
	input  logic [7:0]  read_data,
	input  logic [7:0]  pending_jobs,
	input  logic [8:0]  used_bytes,
	output int unsigned fail_count,
	output int unsigned results_owed
);

	// One result beat as the block reports it
	typedef struct packed {
		logic       ok;
		logic [5:0] next_type;
		logic [7:0] read_data;
		logic [7:0] pending_jobs;
		logic [8:0] used_bytes;
	} ring_status_t;

	// Shadow ring and record bookkeeping
	logic [7:0]   ring_mem [RING_BYTES];
	int unsigned  head_at;
	int unsigned  tail_at;
	int unsigned  used_cnt;
	logic [7:0]   job_cnt;
	int unsigned  wr_hdr_at;
	int unsigned  wr_left;
	bit           wr_open;
	int unsigned  rd_hdr_at;
	int unsigned  rd_left;
	bit           rd_open;

	ring_status_t expected_status [$];
	int unsigned  mismatches = 0;

	function automatic int unsigned ring_next(input int unsigned p);
		return (p + 1) % RING_BYTES;
	endfunction

	// Apply one command to the shadow ring and return the status it reports
	function automatic ring_status_t apply_action(input logic [2:0] act,
		input logic [5:0] rtype, input logic [8:0] rlen, input logic [7:0] wdata);
		ring_status_t st;
		logic [7:0]   hdr;
		st = '0;
		case (act)
			ACT_QUERY: begin
				st.ok = 1'b1;
			end
			ACT_OPEN_WR: begin
				// reserve only when the cell at the head is neither locked nor valid
				hdr = ring_mem[head_at];
				if (!wr_open && rlen != 0 && int'(rlen) <= RING_BYTES - int'(used_cnt) &&
				    (hdr & HDR_LOCKED_VALID) == '0) begin
					ring_mem[head_at] = HDR_LOCKED | {2'b00, rtype};
					wr_hdr_at = head_at;
					head_at   = ring_next(head_at);
					wr_left   = rlen - 1;
					used_cnt  = used_cnt + rlen;
					wr_open   = 1'b1;
					st.ok     = 1'b1;
				end
			end
			ACT_WR_BYTE: begin
				if (wr_open && wr_left != 0) begin
					ring_mem[head_at] = wdata;
					head_at = ring_next(head_at);
					wr_left--;
					st.ok = 1'b1;
				end
			end
			ACT_CLOSE_WR: begin
				if (wr_open && wr_left == 0 && ring_mem[wr_hdr_at][5:0] == rtype) begin
					ring_mem[wr_hdr_at] = HDR_VALID | {2'b00, rtype};
					job_cnt = job_cnt + 8'd1;
					wr_open = 1'b0;
					st.ok   = 1'b1;
				end
			end
			ACT_OPEN_RD: begin
				// the tail header must match the type and be valid and unlocked
				hdr = ring_mem[tail_at];
				if (!rd_open && rlen != 0 && hdr[5:0] == rtype && rlen <= used_cnt &&
				    (hdr & HDR_LOCKED) == '0 && (hdr & HDR_VALID) != '0) begin
					ring_mem[tail_at] = HDR_LOCKED_VALID | {2'b00, rtype};
					rd_hdr_at = tail_at;
					tail_at   = ring_next(tail_at);
					rd_left   = rlen - 1;
					used_cnt  = used_cnt - rlen;
					rd_open   = 1'b1;
					st.ok     = 1'b1;
				end
			end
			ACT_RD_BYTE: begin
				if (rd_open && rd_left != 0) begin
					st.read_data      = ring_mem[tail_at];
					ring_mem[tail_at] = '0;
					tail_at = ring_next(tail_at);
					rd_left--;
					st.ok = 1'b1;
				end
			end
			ACT_CLOSE_RD: begin
				if (rd_open && rd_left == 0 && ring_mem[rd_hdr_at][5:0] == rtype) begin
					ring_mem[rd_hdr_at] = {2'b00, EMPTY_CODE};
					job_cnt = job_cnt - 8'd1;
					rd_open = 1'b0;
					st.ok   = 1'b1;
				end
			end
			default: begin
				// unused code: ignored
			end
		endcase
		hdr = ring_mem[tail_at];
		st.next_type    = ((hdr & HDR_LOCKED) == '0 && (hdr & HDR_VALID) != '0) ?
		                  hdr[5:0] : EMPTY_CODE;
		st.pending_jobs = job_cnt;
		st.used_bytes   = 9'(used_cnt);
		return st;
	endfunction

	task automatic check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Results are matched before the new command is predicted
	always @(posedge clk or negedge arst_n) begin
		ring_status_t want;
		if (!arst_n) begin
			foreach (ring_mem[i]) ring_mem[i] = '0;
			head_at   = 0;
			tail_at   = 0;
			used_cnt  = 0;
			job_cnt   = '0;
			wr_hdr_at = 0;
			wr_left   = 0;
			wr_open   = 1'b0;
			rd_hdr_at = 0;
			rd_left   = 0;
			rd_open   = 1'b0;
			expected_status.delete();
			results_owed <= 0;
		end else begin
			if (done) begin
				if (expected_status.size() == 0) begin
					$display("%0t ns: result beat with no command waiting", $time);
					mismatches++;
				end else begin
					want = expected_status.pop_front();
					check_field("ok", want.ok, ok);
					check_field("next_type", want.next_type, next_type);
					check_field("read_data", want.read_data, read_data);
					check_field("pending_jobs", want.pending_jobs, pending_jobs);
					check_field("used_bytes", want.used_bytes, used_bytes);
				end
			end
			if (start && !busy)
				expected_status.push_back(apply_action(action, record_type,
					record_length, write_data));
			results_owed <= expected_status.size();
		end
		fail_count <= mismatches;
	end

endmodule

[tb/tagged_record_ring_buffer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_record_ring_buffer_tb
// Drives command beats into the tagged record ring buffer: directed misuse
// and boundary cases, then random interleaved write and read records mixed
// with refused and harmless commands. The checker beside the block predicts and compares
// every result beat.
// ----------------------------------------------------------------------------
module tagged_record_ring_buffer_tb;
	import trrb_pkg::*;

	localparam logic [2:0] ACT_UNUSED  = 3'd7;
	localparam int         STALL_LIMIT = 2000;
	localparam int         RAND_STEPS  = 480;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  action;
	logic [5:0]  record_type;
	logic [8:0]  record_length;
	logic [7:0]  write_data;
	logic        done;
	logic        ok;
	logic [5:0]  next_type;
	logic [7:0]  read_data;
	logic [7:0]  pending_jobs;
	logic [8:0]  used_bytes;
	int unsigned fail_count;
	int unsigned results_owed;

	// Stimulus bookkeeping: committed records and the open write / read
	typedef struct {
		logic [5:0]  rtype;
		int unsigned rlen;
	} record_t;

	record_t     ready_records [$];
	bit          wr_active;
	logic [5:0]  wr_type;
	int unsigned wr_len;
	int unsigned wr_left;
	bit          rd_active;
	logic [5:0]  rd_type;
	int unsigned rd_len;
	int unsigned rd_left;
	int unsigned used_total;
	bit          steady;

	tagged_record_ring_buffer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.record_type   (record_type),
		.record_length (record_length),
		.write_data    (write_data),
		.done          (done),
		.ok            (ok),
		.next_type     (next_type),
		.read_data     (read_data),
		.pending_jobs  (pending_jobs),
		.used_bytes    (used_bytes)
	);

	trrb_record_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.record_type   (record_type),
		.record_length (record_length),
		.write_data    (write_data),
		.done          (done),
		.ok            (ok),
		.next_type     (next_type),
		.read_data     (read_data),
		.pending_jobs  (pending_jobs),
		.used_bytes    (used_bytes),
		.fail_count    (fail_count),
		.results_owed  (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// One command beat, with an occasional gap in front of it
	task automatic issue(input logic [2:0] act, input logic [5:0] rtype,
		input logic [8:0] rlen, input logic [7:0] wdata);
		int unsigned gap;
		gap = (!steady && $urandom_range(0, 99) < 9) ? $urandom_range(1, 6) : 0;
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start         <= 1'b1;
		action        <= act;
		record_type   <= rtype;
		record_length <= rlen;
		write_data    <= wdata;
		do @(posedge clk); while (busy);
	endtask

	// Stop sending until every outstanding result beat has come back
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (results_owed != 0) @(posedge clk);
	endtask

	// Advance the writer by one beat: open, payload byte or close
	task automatic writer_step(input int unsigned want_len);
		int unsigned room;
		logic [5:0]  t;
		room = RING_BYTES - used_total - (rd_active ? rd_len : 0);
		t    = 6'($urandom_range(0, 63));
		if (!wr_active) begin
			if (room == 0) begin
				// ring full, or head sits on the locked header being read
				issue(ACT_OPEN_WR, t, 9'($urandom_range(1, RING_BYTES)), 8'($urandom));
			end else begin
				if (want_len > room)
					want_len = room;
				issue(ACT_OPEN_WR, t, 9'(want_len), 8'($urandom));
				wr_active  = 1'b1;
				wr_type    = t;
				wr_len     = want_len;
				wr_left    = want_len - 1;
				used_total = used_total + want_len;
			end
		end else if (wr_left != 0) begin
			issue(ACT_WR_BYTE, t, 9'($urandom), 8'($urandom));
			wr_left--;
		end else begin
			issue(ACT_CLOSE_WR, wr_type, 9'($urandom), 8'($urandom));
			ready_records.push_back('{wr_type, wr_len});
			wr_active = 1'b0;
		end
	endtask

	// Advance the reader by one beat: open, payload byte or close
	task automatic reader_step();
		record_t rec;
		if (!rd_active) begin
			if (ready_records.size() == 0) begin
				// nothing committed at the tail: refused
				issue(ACT_OPEN_RD, 6'($urandom), 9'($urandom_range(1, RING_BYTES)),
					8'($urandom));
			end else begin
				rec = ready_records.pop_front();
				issue(ACT_OPEN_RD, rec.rtype, 9'(rec.rlen), 8'($urandom));
				rd_active  = 1'b1;
				rd_type    = rec.rtype;
				rd_len     = rec.rlen;
				rd_left    = rec.rlen - 1;
				used_total = used_total - rec.rlen;
			end
		end else if (rd_left != 0) begin
			issue(ACT_RD_BYTE, 6'($urandom), 9'($urandom), 8'($urandom));
			rd_left--;
		end else begin
			issue(ACT_CLOSE_RD, rd_type, 9'($urandom), 8'($urandom));
			rd_active = 1'b0;
		end
	endtask

	// A command the block must refuse or that changes nothing
	task automatic stray_item();
		logic [5:0] t;
		logic [8:0] l;
		logic [7:0] d;
		t = 6'($urandom);
		l = 9'($urandom_range(0, RING_BYTES));
		d = 8'($urandom);
		case ($urandom_range(0, 9))
			0: issue(ACT_QUERY, t, 9'($urandom), d);
			1: issue(ACT_UNUSED, t, 9'($urandom), d);
			2: issue(ACT_OPEN_WR, t, '0, d);
			3: issue(ACT_OPEN_RD, t, '0, d);
			4: issue(ACT_CLOSE_WR, wr_active ? wr_type ^ 6'($urandom_range(1, 63)) : t, l, d);
			5: issue(ACT_CLOSE_RD, rd_active ? rd_type ^ 6'($urandom_range(1, 63)) : t, l, d);
			6: begin
				if (!wr_active || wr_left == 0)
					issue(ACT_WR_BYTE, t, l, d);
				else
					issue(ACT_QUERY, t, l, d);
			end
			7: begin
				if (!rd_active || rd_left == 0)
					issue(ACT_RD_BYTE, t, l, d);
				else
					issue(ACT_QUERY, t, l, d);
			end
			8: begin
				// second open, or a length above the free space
				if (wr_active)
					issue(ACT_OPEN_WR, t, l, d);
				else if (used_total != 0)
					issue(ACT_OPEN_WR, t,
						9'($urandom_range(RING_BYTES - used_total + 1, RING_BYTES)), d);
				else
					issue(ACT_QUERY, t, l, d);
			end
			default: begin
				// second open, wrong type, or a length above the used bytes
				if (rd_active || ready_records.size() == 0)
					issue(ACT_OPEN_RD, t, l, d);
				else if (used_total < RING_BYTES && $urandom_range(0, 1))
					issue(ACT_OPEN_RD, ready_records[0].rtype,
						9'($urandom_range(used_total + 1, RING_BYTES)), d);
				else
					issue(ACT_OPEN_RD, ready_records[0].rtype ^ 6'($urandom_range(1, 63)),
						9'(ready_records[0].rlen), d);
			end
		endcase
	endtask

	// Watchdog: ends the run when no beat moves for too long
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		int unsigned steps;
		int unsigned len;
		arst_n        = 1'b0;
		start         = 1'b0;
		action        = ACT_QUERY;
		record_type   = '0;
		record_length = '0;
		write_data    = '0;
		wr_active     = 1'b0;
		wr_type       = '0;
		wr_len        = 0;
		wr_left       = 0;
		rd_active     = 1'b0;
		rd_type       = '0;
		rd_len        = 0;
		rd_left       = 0;
		used_total    = 0;
		steady        = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: misuse on an empty ring, then one short record end to end
		issue(ACT_QUERY, 6'h3F, 9'h1FF, 8'hFF);
		issue(ACT_UNUSED, 6'h15, 9'd3, 8'hA5);
		issue(ACT_OPEN_RD, 6'd0, 9'd1, 8'h00);
		issue(ACT_RD_BYTE, 6'd0, 9'd1, 8'h00);
		issue(ACT_CLOSE_RD, 6'd0, 9'd1, 8'h00);
		issue(ACT_WR_BYTE, 6'd0, 9'd1, 8'h5A);
		issue(ACT_CLOSE_WR, 6'd0, 9'd1, 8'h00);
		issue(ACT_OPEN_WR, 6'd7, 9'd0, 8'h00);
		issue(ACT_OPEN_WR, 6'h3F, 9'd3, 8'h00);
		issue(ACT_OPEN_WR, 6'd1, 9'd1, 8'h00);
		issue(ACT_CLOSE_WR, 6'h3F, 9'd3, 8'h00);
		issue(ACT_WR_BYTE, 6'd0, 9'd0, 8'hFF);
		issue(ACT_WR_BYTE, 6'h3F, 9'h1FF, 8'h00);
		issue(ACT_WR_BYTE, 6'd0, 9'd0, 8'h77);
		issue(ACT_CLOSE_WR, 6'd0, 9'd3, 8'h00);
		issue(ACT_CLOSE_WR, 6'h3F, 9'd3, 8'h00);
		issue(ACT_OPEN_WR, 6'd2, 9'd256, 8'h00);
		issue(ACT_OPEN_RD, 6'h3F, 9'd0, 8'h00);
		issue(ACT_OPEN_RD, 6'h3E, 9'd3, 8'h00);
		issue(ACT_OPEN_RD, 6'h3F, 9'd4, 8'h00);
		issue(ACT_OPEN_RD, 6'h3F, 9'd3, 8'h00);
		issue(ACT_OPEN_RD, 6'h3F, 9'd3, 8'h00);
		issue(ACT_CLOSE_RD, 6'h3F, 9'd3, 8'h00);
		issue(ACT_RD_BYTE, 6'd0, 9'd0, 8'h00);
		issue(ACT_RD_BYTE, 6'd0, 9'd0, 8'h00);
		issue(ACT_RD_BYTE, 6'd0, 9'd0, 8'h00);
		issue(ACT_CLOSE_RD, 6'd0, 9'd3, 8'h00);
		issue(ACT_CLOSE_RD, 6'h3F, 9'd3, 8'h00);
		drain();

		// Random: interleaved records with stray commands mixed in
		steps = 0;
		while (steps < RAND_STEPS) begin
			steady = (steps >= 250 && steps < 400);
			if ($urandom_range(0, 99) < 15) begin
				stray_item();
			end else begin
				if ($urandom_range(0, 1)) begin
					len = $urandom_range(0, 99);
					if (len < 70)
						len = $urandom_range(1, 6);
					else if (len < 95)
						len = $urandom_range(7, 40);
					else
						len = $urandom_range(41, RING_BYTES);
					writer_step(len);
				end else begin
					reader_step();
				end
				steps++;
				if (steps == RAND_STEPS / 2)
					drain();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && results_owed == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[tagged_record_ring_buffer.f]
hdl/trrb_pkg.sv
hdl/trrb_ram.sv
hdl/trrb_exec.sv
hdl/tagged_record_ring_buffer.sv
tb/trrb_record_checker.sv
tb/tagged_record_ring_buffer_tb.sv
